// ===== rtl/rbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rbfp_pkg: shared types and constants for the bus frame parser
// Frame layout constants, the payload capture slots, and the structs that
// carry a finished frame and a decoded result between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rbfp_pkg;

   // start pattern and header constants
   localparam logic [7:0]  SYNC_BYTE      = 8'hA5;
   localparam logic [23:0] PREAMBLE_TAIL  = 24'hFF00FF;
   localparam logic [7:0]  HEADER_LAST    = 8'd4;

   // controller status broadcast
   localparam logic [7:0]  CTRL_SRC       = 8'h10;
   localparam logic [7:0]  CTRL_DST       = 8'h0F;
   localparam logic [7:0]  CTRL_CMD       = 8'h02;
   localparam logic [7:0]  CTRL_MIN_LEN   = 8'h1D;

   // pump status
   localparam logic [7:0]  PUMP_DST       = 8'h10;
   localparam logic [7:0]  PUMP_SRC_FIRST = 8'h60;
   localparam logic [7:0]  PUMP_SRC_LAST  = 8'h63;
   localparam logic [7:0]  PUMP_CMD       = 8'h07;
   localparam logic [7:0]  PUMP_MIN_LEN   = 8'h0F;

   // frame classes
   localparam logic [1:0]  CLASS_NONE     = 2'd0;
   localparam logic [1:0]  CLASS_CTRL     = 2'd1;
   localparam logic [1:0]  CLASS_PUMP     = 2'd2;

   // payload capture slots
   localparam int          NUM_SLOTS      = 10;
   localparam logic [3:0]  SLOT_P0        = 4'd0;
   localparam logic [3:0]  SLOT_P2        = 4'd1;
   localparam logic [3:0]  SLOT_P3        = 4'd2;
   localparam logic [3:0]  SLOT_P4        = 4'd3;
   localparam logic [3:0]  SLOT_P5        = 4'd4;
   localparam logic [3:0]  SLOT_P6        = 4'd5;
   localparam logic [3:0]  SLOT_P7        = 4'd6;
   localparam logic [3:0]  SLOT_P14       = 4'd7;
   localparam logic [3:0]  SLOT_P15       = 4'd8;
   localparam logic [3:0]  SLOT_P18       = 4'd9;
   localparam logic [3:0]  NO_SLOT        = 4'd10;

   typedef logic [NUM_SLOTS-1:0][7:0] payload_type;

   // everything known about a frame before its last checksum byte
   typedef struct packed {
      logic [7:0]  dest_addr;
      logic [7:0]  source_addr;
      logic [7:0]  command_code;
      logic [7:0]  payload_len;
      logic [15:0] running_sum;
      logic [7:0]  checksum_high;
      payload_type payload;
   } frame_type;

   // one decoded result transaction
   typedef struct packed {
      logic [1:0]  frame_class;
      logic        checksum_ok;
      logic [7:0]  source_addr;
      logic [7:0]  dest_addr;
      logic [7:0]  command_code;
      logic [7:0]  payload_len;
      logic [7:0]  status_byte;
      logic [15:0] value_a;
      logic [15:0] value_b;
      logic [7:0]  value_c;
      logic [3:0]  circuit_flags;
      logic [1:0]  pump_index;
   } result_type;

   // payload position to capture slot
   function automatic logic [3:0] slot_for(input logic [7:0] pos);
      logic [3:0] slot;
      case (pos)
         8'd0:    slot = SLOT_P0;
         8'd2:    slot = SLOT_P2;
         8'd3:    slot = SLOT_P3;
         8'd4:    slot = SLOT_P4;
         8'd5:    slot = SLOT_P5;
         8'd6:    slot = SLOT_P6;
         8'd7:    slot = SLOT_P7;
         8'd14:   slot = SLOT_P14;
         8'd15:   slot = SLOT_P15;
         8'd18:   slot = SLOT_P18;
         default: slot = NO_SLOT;
      endcase
      return slot;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rbfp_parser.sv =====
// ----------------------------------------------------------------------------
// rbfp_parser: byte-serial frame tracker
// Hunts for the start pattern, then walks header, payload and checksum,
// keeping the running sum, header bytes and the captured payload positions.
// ----------------------------------------------------------------------------
`default_nettype none

module rbfp_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_take,
   input  wire logic [7:0]         rx_byte,
   output      logic               at_checksum_low,
   output      rbfp_pkg::frame_type frame
);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CHK_HI,
      PH_CHK_LO
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [23:0] recent_ff, recent_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  source_ff, source_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  chk_hi_ff, chk_hi_in;
   logic [7:0]  count_next;
   logic [3:0]  slot;
   rbfp_pkg::payload_type payload_ff;

   assign count_next = count_ff + 8'd1;
   assign slot       = rbfp_pkg::slot_for(count_ff);

   // next state for one accepted byte
   always_comb begin
      phase_in   = phase_ff;
      recent_in  = recent_ff;
      count_in   = count_ff;
      dest_in    = dest_ff;
      source_in  = source_ff;
      command_in = command_ff;
      length_in  = length_ff;
      sum_in     = sum_ff;
      chk_hi_in  = chk_hi_ff;
      if (byte_take) begin
         case (phase_ff)
            PH_HEADER: begin
               sum_in = sum_ff + {8'd0, rx_byte};
               case (count_ff)
                  8'd1:    dest_in    = rx_byte;
                  8'd2:    source_in  = rx_byte;
                  8'd3:    command_in = rx_byte;
                  8'd4:    length_in  = rx_byte;
                  default: ;
               endcase
               if (count_ff >= rbfp_pkg::HEADER_LAST) begin
                  count_in = 8'd0;
                  phase_in = (rx_byte == 8'd0) ? PH_CHK_HI : PH_PAYLOAD;
               end else begin
                  count_in = count_next;
               end
            end
            PH_PAYLOAD: begin
               sum_in   = sum_ff + {8'd0, rx_byte};
               count_in = count_next;
               if (count_next >= length_ff) begin
                  phase_in = PH_CHK_HI;
               end
            end
            PH_CHK_HI: begin
               chk_hi_in = rx_byte;
               phase_in  = PH_CHK_LO;
            end
            PH_CHK_LO: begin
               // frame complete, start hunting with a clean window
               phase_in  = PH_HUNT;
               recent_in = 24'd0;
               count_in  = 8'd0;
            end
            default: begin
               if (rx_byte == rbfp_pkg::SYNC_BYTE &&
                   recent_ff == rbfp_pkg::PREAMBLE_TAIL) begin
                  phase_in  = PH_HEADER;
                  count_in  = 8'd0;
                  sum_in    = {8'd0, rbfp_pkg::SYNC_BYTE};
                  recent_in = 24'd0;
               end else begin
                  phase_in  = PH_HUNT;
                  recent_in = {recent_ff[15:0], rx_byte};
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         recent_ff  <= 24'd0;
         count_ff   <= 8'd0;
         dest_ff    <= 8'd0;
         source_ff  <= 8'd0;
         command_ff <= 8'd0;
         length_ff  <= 8'd0;
         sum_ff     <= 16'd0;
         chk_hi_ff  <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         recent_ff  <= recent_in;
         count_ff   <= count_in;
         dest_ff    <= dest_in;
         source_ff  <= source_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         sum_ff     <= sum_in;
         chk_hi_ff  <= chk_hi_in;
      end
   end

   // payload capture, one fixed slot per decoded position
   always_ff @(posedge clock) begin
      for (int i = 0; i < rbfp_pkg::NUM_SLOTS; i++) begin
         if (byte_take && phase_ff == PH_PAYLOAD && slot == 4'(i)) begin
            payload_ff[i] <= rx_byte;
         end
      end
   end

   assign at_checksum_low = (phase_ff == PH_CHK_LO);

   assign frame.dest_addr     = dest_ff;
   assign frame.source_addr   = source_ff;
   assign frame.command_code  = command_ff;
   assign frame.payload_len   = length_ff;
   assign frame.running_sum   = sum_ff;
   assign frame.checksum_high = chk_hi_ff;
   assign frame.payload       = payload_ff;

endmodule

`default_nettype wire

// ===== rtl/rbfp_classify.sv =====
// ----------------------------------------------------------------------------
// rbfp_classify: checksum check and status decode
// Combines the finished frame with its last checksum byte, checks the sum
// and decodes a controller or pump status frame into result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rbfp_classify (
   input  wire rbfp_pkg::frame_type  frame,
   input  wire logic [7:0]           checksum_low,
   output      rbfp_pkg::result_type result
);

   logic       sum_ok;
   logic       is_ctrl;
   logic       is_pump;
   logic [7:0] equip;

   assign sum_ok = ({frame.checksum_high, checksum_low} == frame.running_sum);
   assign equip  = frame.payload[rbfp_pkg::SLOT_P2];

   // frame type match
   assign is_ctrl = sum_ok &&
                    frame.source_addr  == rbfp_pkg::CTRL_SRC &&
                    frame.dest_addr    == rbfp_pkg::CTRL_DST &&
                    frame.command_code == rbfp_pkg::CTRL_CMD &&
                    frame.payload_len  >= rbfp_pkg::CTRL_MIN_LEN;
   assign is_pump = sum_ok &&
                    frame.dest_addr    == rbfp_pkg::PUMP_DST &&
                    frame.source_addr  >= rbfp_pkg::PUMP_SRC_FIRST &&
                    frame.source_addr  <= rbfp_pkg::PUMP_SRC_LAST &&
                    frame.command_code == rbfp_pkg::PUMP_CMD &&
                    frame.payload_len  >= rbfp_pkg::PUMP_MIN_LEN;

   // field decode
   always_comb begin
      result               = '0;
      result.checksum_ok   = sum_ok;
      result.source_addr   = frame.source_addr;
      result.dest_addr     = frame.dest_addr;
      result.command_code  = frame.command_code;
      result.payload_len   = frame.payload_len;
      if (is_ctrl) begin
         result.frame_class   = rbfp_pkg::CLASS_CTRL;
         result.status_byte   = equip;
         result.value_a       = {8'd0, frame.payload[rbfp_pkg::SLOT_P14]};
         result.value_b       = {8'd0, frame.payload[rbfp_pkg::SLOT_P15]};
         result.value_c       = frame.payload[rbfp_pkg::SLOT_P18];
         // pool, cleaner, light, water feature
         result.circuit_flags = {equip[2], equip[1], equip[0], equip[5]};
      end else if (is_pump) begin
         result.frame_class   = rbfp_pkg::CLASS_PUMP;
         result.status_byte   = frame.payload[rbfp_pkg::SLOT_P0];
         result.value_a       = {frame.payload[rbfp_pkg::SLOT_P3],
                                 frame.payload[rbfp_pkg::SLOT_P4]};
         result.value_b       = {frame.payload[rbfp_pkg::SLOT_P5],
                                 frame.payload[rbfp_pkg::SLOT_P6]};
         result.value_c       = frame.payload[rbfp_pkg::SLOT_P7];
         result.pump_index    = frame.source_addr[1:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rs485_bus_frame_parser.sv =====
// ----------------------------------------------------------------------------
// rs485_bus_frame_parser: RS-485 bus frame parser, additive 16-bit checksum
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_rx_byte
//   rsp_      out        rsp_valid / rsp_stall  frame_class .. pump_index
//
// One received byte per cycle is taken while req_stall is low; the parser
// state registers are the only pipeline stage ahead of the result register.
// A frame's result is loaded at the edge that takes its last checksum byte
// and is offered from the next cycle on.
// Reset returns the parser to hunting with a cleared window; no sweep needed.
// req_stall rises only when a byte would end a frame while an earlier result
// is still held under rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rs485_bus_frame_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_frame_class,
   output      logic        rsp_checksum_ok,
   output      logic [7:0]  rsp_source_addr,
   output      logic [7:0]  rsp_dest_addr,
   output      logic [7:0]  rsp_command_code,
   output      logic [7:0]  rsp_payload_len,
   output      logic [7:0]  rsp_status_byte,
   output      logic [15:0] rsp_value_a,
   output      logic [15:0] rsp_value_b,
   output      logic [7:0]  rsp_value_c,
   output      logic [3:0]  rsp_circuit_flags,
   output      logic [1:0]  rsp_pump_index
);

   logic                 byte_take;
   logic                 at_checksum_low;
   logic                 frame_done;
   logic                 rsp_valid_ff, rsp_valid_in;
   rbfp_pkg::frame_type  frame;
   rbfp_pkg::result_type result;
   rbfp_pkg::result_type rsp_data_ff;

   // hold input only when a frame would end into a full, stalled result slot
   assign req_stall  = rsp_valid_ff && rsp_stall && at_checksum_low;
   assign byte_take  = req_valid && !req_stall;
   assign frame_done = byte_take && at_checksum_low;

   rbfp_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .byte_take       (byte_take),
      .rx_byte         (req_rx_byte),
      .at_checksum_low (at_checksum_low),
      .frame           (frame)
   );

   rbfp_classify u_classify (
      .frame        (frame),
      .checksum_low (req_rx_byte),
      .result       (result)
   );

   // result register
   assign rsp_valid_in = frame_done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_class   = rsp_data_ff.frame_class;
   assign rsp_checksum_ok   = rsp_data_ff.checksum_ok;
   assign rsp_source_addr   = rsp_data_ff.source_addr;
   assign rsp_dest_addr     = rsp_data_ff.dest_addr;
   assign rsp_command_code  = rsp_data_ff.command_code;
   assign rsp_payload_len   = rsp_data_ff.payload_len;
   assign rsp_status_byte   = rsp_data_ff.status_byte;
   assign rsp_value_a       = rsp_data_ff.value_a;
   assign rsp_value_b       = rsp_data_ff.value_b;
   assign rsp_value_c       = rsp_data_ff.value_c;
   assign rsp_circuit_flags = rsp_data_ff.circuit_flags;
   assign rsp_pump_index    = rsp_data_ff.pump_index;

`ifndef NO_ASSERTIONS
   // a decoded class needs a good checksum
   a_class_needs_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_class != rbfp_pkg::CLASS_NONE |-> rsp_checksum_ok)
      else $error("decoded frame class without a good checksum");

   // input is held back only while a result is waiting
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled with no pending result");

   // a taken result is not repeated unless another frame ended
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !frame_done |=> !rsp_valid)
      else $error("result transaction repeated");

   // pump index is only given for pump frames
   a_pump_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pump_index != 2'd0 |-> rsp_frame_class == rbfp_pkg::CLASS_PUMP)
      else $error("pump index on a non-pump frame");
`endif

endmodule

`default_nettype wire

// ===== sim/rs485_bus_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// rs485_bus_frame_parser_tb: self-checking bench for the bus frame parser
// Feeds bus bytes through the request channel and checks every result
// transaction, field by field, against a behavioural predictor of the parser.
// Directed frames cover both decoded classes, checksum failures, near-miss
// headers, empty and maximum payloads and the start pattern hunt. Random
// frames with noise, random idling and back-pressure then follow.
// ----------------------------------------------------------------------------
`default_nettype none

module rs485_bus_frame_parser_tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_BYTES  = 350;
   localparam int RANDOM_FRAMES = 12;

   typedef enum logic [2:0] {HUNT, HEADER, BODY, SUM_HI, SUM_LO} parse_state_type;
   typedef enum {SUM_GOOD, SUM_BAD, SUM_TAIL_FF00} sum_kind_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [1:0]  rsp_frame_class;
   logic        rsp_checksum_ok;
   logic [7:0]  rsp_source_addr;
   logic [7:0]  rsp_dest_addr;
   logic [7:0]  rsp_command_code;
   logic [7:0]  rsp_payload_len;
   logic [7:0]  rsp_status_byte;
   logic [15:0] rsp_value_a;
   logic [15:0] rsp_value_b;
   logic [7:0]  rsp_value_c;
   logic [3:0]  rsp_circuit_flags;
   logic [1:0]  rsp_pump_index;

   // predictor state
   parse_state_type      parse_state = HUNT;
   logic [23:0]          hunt_window = '0;
   logic [7:0]           byte_index  = '0;
   logic [7:0]           hdr_bytes [0:3] = '{default: 8'h00};
   logic [15:0]          run_sum     = '0;
   logic [7:0]           sum_high    = '0;
   logic [7:0]           body_bytes [0:255];
   rbfp_pkg::result_type frame_results_due [$];

   // stimulus and flow control
   logic [7:0] payload_buf [0:254];
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   bit         hold_request  = 1'b0;
   int         hold_cycles   = 0;
   int         stall_left    = 0;
   int         frame_bytes   = 0;
   int         frames_sent   = 0;
   int         error_count   = 0;
   int         cycle_count   = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   rs485_bus_frame_parser u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_class   (rsp_frame_class),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_source_addr   (rsp_source_addr),
      .rsp_dest_addr     (rsp_dest_addr),
      .rsp_command_code  (rsp_command_code),
      .rsp_payload_len   (rsp_payload_len),
      .rsp_status_byte   (rsp_status_byte),
      .rsp_value_a       (rsp_value_a),
      .rsp_value_b       (rsp_value_b),
      .rsp_value_c       (rsp_value_c),
      .rsp_circuit_flags (rsp_circuit_flags),
      .rsp_pump_index    (rsp_pump_index)
   );

   // advance the predictor by one accepted bus byte
   task automatic track_bus_byte(input logic [7:0] b);
      rbfp_pkg::result_type r;
      logic [7:0] eq;
      case (parse_state)
         HEADER: begin
            run_sum = run_sum + {8'h00, b};
            if (byte_index >= 8'd1 && byte_index <= 8'd4) begin
               hdr_bytes[2'(byte_index - 8'd1)] = b;
            end
            if (byte_index >= 8'd4) begin
               byte_index  = 8'd0;
               parse_state = (b == 8'h00) ? SUM_HI : BODY;
            end else begin
               byte_index = byte_index + 8'd1;
            end
         end
         BODY: begin
            run_sum = run_sum + {8'h00, b};
            body_bytes[byte_index] = b;
            byte_index = byte_index + 8'd1;
            if (byte_index >= hdr_bytes[3]) parse_state = SUM_HI;
         end
         SUM_HI: begin
            sum_high    = b;
            parse_state = SUM_LO;
         end
         SUM_LO: begin
            r = '0;
            r.frame_class  = rbfp_pkg::CLASS_NONE;
            r.checksum_ok  = ({sum_high, b} == run_sum);
            r.dest_addr    = hdr_bytes[0];
            r.source_addr  = hdr_bytes[1];
            r.command_code = hdr_bytes[2];
            r.payload_len  = hdr_bytes[3];
            // controller status broadcast
            if (r.checksum_ok && hdr_bytes[1] == rbfp_pkg::CTRL_SRC &&
                hdr_bytes[0] == rbfp_pkg::CTRL_DST &&
                hdr_bytes[2] == rbfp_pkg::CTRL_CMD &&
                hdr_bytes[3] >= rbfp_pkg::CTRL_MIN_LEN) begin
               eq              = body_bytes[2];
               r.frame_class   = rbfp_pkg::CLASS_CTRL;
               r.status_byte   = eq;
               r.value_a       = {8'h00, body_bytes[14]};
               r.value_b       = {8'h00, body_bytes[15]};
               r.value_c       = body_bytes[18];
               r.circuit_flags = {eq[2], eq[1], eq[0], eq[5]};
            // pump status
            end else if (r.checksum_ok && hdr_bytes[0] == rbfp_pkg::PUMP_DST &&
                         hdr_bytes[1] >= rbfp_pkg::PUMP_SRC_FIRST &&
                         hdr_bytes[1] <= rbfp_pkg::PUMP_SRC_LAST &&
                         hdr_bytes[2] == rbfp_pkg::PUMP_CMD &&
                         hdr_bytes[3] >= rbfp_pkg::PUMP_MIN_LEN) begin
               r.frame_class = rbfp_pkg::CLASS_PUMP;
               r.status_byte = body_bytes[0];
               r.value_a     = {body_bytes[3], body_bytes[4]};
               r.value_b     = {body_bytes[5], body_bytes[6]};
               r.value_c     = body_bytes[7];
               r.pump_index  = 2'(hdr_bytes[1] - rbfp_pkg::PUMP_SRC_FIRST);
            end
            frame_results_due.push_back(r);
            parse_state = HUNT;
            hunt_window = '0;
            byte_index  = 8'd0;
         end
         default: begin
            if (b == rbfp_pkg::SYNC_BYTE && hunt_window == rbfp_pkg::PREAMBLE_TAIL) begin
               parse_state = HEADER;
               byte_index  = 8'd0;
               run_sum     = 16'(rbfp_pkg::SYNC_BYTE);
               hunt_window = '0;
            end else begin
               hunt_window = {hunt_window[15:0], b};
            end
         end
      endcase
   endtask

   // offer one byte, optionally after an idle burst, and wait for acceptance
   task automatic send_byte(input logic [7:0] b);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_bus_byte(b);
   endtask

   // stop sending until every predicted result has been taken
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic fill_payload();
      for (int i = 0; i < 255; i++) payload_buf[8'(i)] = 8'($urandom);
   endtask

   // preamble, sync, header, payload_buf contents and checksum
   task automatic send_frame(input logic [7:0] dst, input logic [7:0] src,
                             input logic [7:0] cmd, input logic [7:0] len,
                             input sum_kind_type sum_kind, input bit long_pre);
      logic [15:0] sum;
      logic [7:0]  head [0:4];
      head[0] = 8'($urandom);
      head[1] = dst;
      head[2] = src;
      head[3] = cmd;
      head[4] = len;
      if (long_pre) repeat (7) send_byte(8'hFF);
      send_byte(rbfp_pkg::PREAMBLE_TAIL[23:16]);
      send_byte(rbfp_pkg::PREAMBLE_TAIL[15:8]);
      send_byte(rbfp_pkg::PREAMBLE_TAIL[7:0]);
      send_byte(rbfp_pkg::SYNC_BYTE);
      sum = 16'(rbfp_pkg::SYNC_BYTE);
      for (int i = 0; i < 5; i++) begin
         send_byte(head[3'(i)]);
         sum = sum + {8'h00, head[3'(i)]};
      end
      for (int i = 0; i < int'(len); i++) begin
         send_byte(payload_buf[8'(i)]);
         sum = sum + {8'h00, payload_buf[8'(i)]};
      end
      case (sum_kind)
         SUM_BAD:       sum = sum ^ 16'($urandom_range(1, 65535));
         SUM_TAIL_FF00: sum = 16'hFF00;
         default:       ;
      endcase
      send_byte(sum[15:8]);
      send_byte(sum[7:0]);
      frame_bytes = frame_bytes + 8 + int'(len);
      frames_sent = frames_sent + 1;
   endtask

   // hunt-phase noise, biased towards pieces of the start pattern
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0:       b = 8'hFF;
         1:       b = 8'h00;
         2:       b = rbfp_pkg::SYNC_BYTE;
         default: b = 8'($urandom);
      endcase
      return b;
   endfunction

   task automatic send_noise(input int count);
      repeat (count) send_byte(noise_byte());
   endtask

   // mostly well-formed frames of either class, some near misses and noise
   task automatic send_random_frame();
      int         kind;
      logic [7:0] dst, src, cmd, len;
      fill_payload();
      if ($urandom_range(0, 2) == 0) send_noise($urandom_range(1, 6));
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         dst = rbfp_pkg::CTRL_DST;
         src = rbfp_pkg::CTRL_SRC;
         cmd = rbfp_pkg::CTRL_CMD;
         len = rbfp_pkg::CTRL_MIN_LEN + 8'($urandom_range(0, 6));
      end else if (kind < 70) begin
         dst = rbfp_pkg::PUMP_DST;
         src = rbfp_pkg::PUMP_SRC_FIRST + 8'($urandom_range(0, 3));
         cmd = rbfp_pkg::PUMP_CMD;
         len = rbfp_pkg::PUMP_MIN_LEN + 8'($urandom_range(0, 4));
      end else begin
         dst = 8'($urandom);
         src = 8'($urandom);
         cmd = 8'($urandom);
         len = ($urandom_range(0, 29) == 0) ? 8'hFF : 8'($urandom_range(0, 12));
      end
      // near miss on one header field
      if (kind < 70 && $urandom_range(0, 6) == 0) begin
         case ($urandom_range(0, 3))
            0:       dst = dst ^ 8'(1 << $urandom_range(0, 7));
            1:       src = src ^ 8'(1 << $urandom_range(0, 7));
            2:       cmd = cmd ^ 8'(1 << $urandom_range(0, 7));
            default: len = (kind < 35) ? rbfp_pkg::CTRL_MIN_LEN - 8'd1 :
                                         rbfp_pkg::PUMP_MIN_LEN - 8'd1;
         endcase
      end
      send_frame(dst, src, cmd, len,
                 ($urandom_range(0, 7) == 0) ? SUM_BAD : SUM_GOOD,
                 $urandom_range(0, 3) == 0);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count = error_count + 1;
      end
   endtask

   // compare one result transaction with the oldest prediction
   task automatic check_frame_result();
      rbfp_pkg::result_type want;
      if (frame_results_due.size() == 0) begin
         $error("result transaction with none predicted, source 0x%0h", rsp_source_addr);
         error_count = error_count + 1;
      end else begin
         want = frame_results_due.pop_front();
         check_field("frame_class",   16'(want.frame_class),   16'(rsp_frame_class));
         check_field("checksum_ok",   16'(want.checksum_ok),   16'(rsp_checksum_ok));
         check_field("source_addr",   16'(want.source_addr),   16'(rsp_source_addr));
         check_field("dest_addr",     16'(want.dest_addr),     16'(rsp_dest_addr));
         check_field("command_code",  16'(want.command_code),  16'(rsp_command_code));
         check_field("payload_len",   16'(want.payload_len),   16'(rsp_payload_len));
         check_field("status_byte",   16'(want.status_byte),   16'(rsp_status_byte));
         check_field("value_a",       want.value_a,            rsp_value_a);
         check_field("value_b",       want.value_b,            rsp_value_b);
         check_field("value_c",       16'(want.value_c),       16'(rsp_value_c));
         check_field("circuit_flags", 16'(want.circuit_flags), 16'(rsp_circuit_flags));
         check_field("pump_index",    16'(want.pump_index),    16'(rsp_pump_index));
      end
   endtask

   // result side: check accepted transactions, then drive the stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_frame_result();
         if (hold_request) begin
            hold_cycles  = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_cycles > 0) begin
            rsp_stall  <= 1'b1;
            hold_cycles = hold_cycles - 1;
         end else if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left  = stall_left - 1;
         end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            rsp_stall  <= 1'b1;
            stall_left  = $urandom_range(0, 7);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // controller broadcasts at the minimum length and above, equipment extremes
   task automatic test_controller_status();
      send_idle_pct = 10;
      recv_idle_pct = 10;
      fill_payload();
      payload_buf[2]  = 8'h27;
      payload_buf[14] = 8'h00;
      payload_buf[15] = 8'hFF;
      payload_buf[18] = 8'h55;
      send_frame(rbfp_pkg::CTRL_DST, rbfp_pkg::CTRL_SRC, rbfp_pkg::CTRL_CMD,
                 rbfp_pkg::CTRL_MIN_LEN, SUM_GOOD, 1'b1);
      fill_payload();
      payload_buf[2]  = 8'hD8;
      payload_buf[14] = 8'hFF;
      payload_buf[15] = 8'h00;
      send_frame(rbfp_pkg::CTRL_DST, rbfp_pkg::CTRL_SRC, rbfp_pkg::CTRL_CMD,
                 8'h24, SUM_GOOD, 1'b0);
   endtask

   // pump status from the first and last pump address, value extremes
   task automatic test_pump_status();
      fill_payload();
      payload_buf[0] = 8'hFF;
      for (int i = 3; i <= 7; i++) payload_buf[8'(i)] = 8'hFF;
      send_frame(rbfp_pkg::PUMP_DST, rbfp_pkg::PUMP_SRC_FIRST, rbfp_pkg::PUMP_CMD,
                 rbfp_pkg::PUMP_MIN_LEN, SUM_GOOD, 1'b0);
      fill_payload();
      payload_buf[0] = 8'h00;
      for (int i = 3; i <= 7; i++) payload_buf[8'(i)] = 8'h00;
      send_frame(rbfp_pkg::PUMP_DST, rbfp_pkg::PUMP_SRC_LAST, rbfp_pkg::PUMP_CMD,
                 8'h13, SUM_GOOD, 1'b1);
   endtask

   // bad checksum and headers that just miss a decoded class
   task automatic test_rejected_frames();
      fill_payload();
      send_frame(rbfp_pkg::CTRL_DST, rbfp_pkg::CTRL_SRC, rbfp_pkg::CTRL_CMD,
                 rbfp_pkg::CTRL_MIN_LEN, SUM_BAD, 1'b0);
      send_frame(rbfp_pkg::CTRL_DST, rbfp_pkg::CTRL_SRC, rbfp_pkg::CTRL_CMD,
                 rbfp_pkg::CTRL_MIN_LEN - 8'd1, SUM_GOOD, 1'b0);
      send_frame(rbfp_pkg::PUMP_DST, rbfp_pkg::PUMP_SRC_LAST + 8'd1, rbfp_pkg::PUMP_CMD,
                 rbfp_pkg::PUMP_MIN_LEN, SUM_GOOD, 1'b0);
      send_frame(rbfp_pkg::PUMP_DST, rbfp_pkg::PUMP_SRC_FIRST - 8'd1, rbfp_pkg::PUMP_CMD,
                 rbfp_pkg::PUMP_MIN_LEN, SUM_GOOD, 1'b0);
      send_frame(rbfp_pkg::PUMP_DST, rbfp_pkg::PUMP_SRC_FIRST, rbfp_pkg::CTRL_CMD,
                 rbfp_pkg::PUMP_MIN_LEN, SUM_GOOD, 1'b0);
      send_frame(rbfp_pkg::PUMP_DST, rbfp_pkg::PUMP_SRC_FIRST, rbfp_pkg::PUMP_CMD,
                 rbfp_pkg::PUMP_MIN_LEN, SUM_BAD, 1'b0);
   endtask

   // empty payload and the longest payload, header bytes at their extremes
   task automatic test_length_extremes();
      fill_payload();
      send_frame(8'h00, 8'hFF, 8'h00, 8'h00, SUM_GOOD, 1'b0);
      send_frame(8'hFF, 8'h00, 8'hFF, 8'hFF, SUM_GOOD, 1'b0);
   endtask

   // start pattern inside a frame, cleared window after a frame, broken preambles
   task automatic test_hunt_window();
      fill_payload();
      payload_buf[4] = rbfp_pkg::PREAMBLE_TAIL[23:16];
      payload_buf[5] = rbfp_pkg::PREAMBLE_TAIL[15:8];
      payload_buf[6] = rbfp_pkg::PREAMBLE_TAIL[7:0];
      payload_buf[7] = rbfp_pkg::SYNC_BYTE;
      send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'd10, SUM_GOOD, 1'b0);
      // checksum bytes ff 00 then ff a5 must not open a frame
      send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'd3, SUM_TAIL_FF00, 1'b0);
      send_byte(8'hFF);
      send_byte(rbfp_pkg::SYNC_BYTE);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(rbfp_pkg::SYNC_BYTE);
      send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'd1, SUM_GOOD, 1'b1);
   endtask

   // long receiver hold while short frames keep coming, then drain
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_for_results();
      hold_request = 1'b1;
      repeat (4) begin
         fill_payload();
         send_frame(8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom_range(0, 3)), SUM_GOOD, 1'b0);
      end
      wait_for_results();
   endtask

   // random frames with idling that changes from frame to frame
   task automatic test_random_traffic();
      int first_bytes, first_frames;
      first_bytes  = frame_bytes;
      first_frames = frames_sent;
      while (frame_bytes - first_bytes < RANDOM_BYTES ||
             frames_sent - first_frames < RANDOM_FRAMES) begin
         case ($urandom_range(0, 3))
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 10; recv_idle_pct = 10; end
            2: begin send_idle_pct = 30; recv_idle_pct = 5;  end
            default: begin send_idle_pct = 5; recv_idle_pct = 30; end
         endcase
         send_random_frame();
      end
   endtask

   // closing stretch at full rate on both sides
   task automatic test_quiet_tail();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (8) send_random_frame();
   endtask

   // test sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_controller_status();
      test_pump_status();
      test_rejected_frames();
      test_length_extremes();
      test_hunt_window();
      test_backpressure();
      test_random_traffic();
      test_quiet_tail();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
